// File: design/grid_bin_start_top_defines.svh
// grid_bin_start_top_defines.svh
// assertion macros for the grid bin start checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef GRID_BIN_START_TOP_DEFINES_SVH
`define GRID_BIN_START_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define GBS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define GBS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/gbs_pkg.sv
// gbs_pkg: types, codes and helpers for the grid bin start block
// no dependencies; used by grid_bin_start_top and gbs_checker
`default_nettype none

package gbs_pkg;

  localparam int unsigned DATA_W   = 64;
  localparam int unsigned NARROW_W = 32;
  localparam int unsigned REM_W    = DATA_W - 1;
  localparam int unsigned WIDE_W   = DATA_W + 2;

  // type of the incoming value
  typedef enum logic [1:0] {
    MODE_INT32 = 2'd0,
    MODE_INT64 = 2'd1,
    MODE_DATE  = 2'd2,
    MODE_TS    = 2'd3
  } mode_t;

  // result status
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SIZE      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NONFINITE = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic {
    CFG_BIN_SIZE   = 1'b0,
    CFG_BIN_ORIGIN = 1'b1
  } cfg_idx_t;

  // type limits, sign-extended to the full data width
  localparam logic [DATA_W-1:0] S64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] S64_MIN     = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] INT32_MAX_X = 64'h0000_0000_7FFF_FFFF;
  localparam logic [DATA_W-1:0] INT32_MIN_X = 64'hFFFF_FFFF_8000_0000;

  // one item in flight; mag holds |d| in the divider, then the floor remainder
  typedef struct packed {
    logic              narrow;
    logic              done;
    status_t           status;
    logic [DATA_W-1:0] d;
    logic [DATA_W-1:0] mag;
    logic [REM_W-1:0]  rem;
  } item_t;

  // low half sign-extended in the 32-bit modes
  function automatic logic [DATA_W-1:0] narrow_ext(logic [DATA_W-1:0] x, logic narrow);
    return narrow ? {{(DATA_W-NARROW_W){x[NARROW_W-1]}}, x[NARROW_W-1:0]} : x;
  endfunction

  function automatic logic [DATA_W-1:0] lo_of(logic narrow);
    return narrow ? INT32_MIN_X : S64_MIN;
  endfunction

  function automatic logic [DATA_W-1:0] hi_of(logic narrow);
    return narrow ? INT32_MAX_X : S64_MAX;
  endfunction

  // sign extension by two guard bits for overflow checks
  function automatic logic signed [WIDE_W-1:0] sx_wide(logic [DATA_W-1:0] x);
    return $signed({{2{x[DATA_W-1]}}, x});
  endfunction

  // one restoring remainder step: shift in a dividend bit, subtract if it fits
  function automatic logic [REM_W-1:0] rem_step(logic [REM_W-1:0] rem, logic din,
                                                logic [DATA_W-1:0] size);
    logic [DATA_W-1:0] part;
    logic [DATA_W:0]   diff;
    part = {rem, din};
    diff = {1'b0, part} - {1'b0, size};
    return diff[DATA_W] ? part[REM_W-1:0] : diff[REM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: design/grid_bin_start_top.sv
// grid_bin_start_top: start of the grid bin holding a value, pipelined
// depends on gbs_pkg
//
// Usage:
//   in_*  : value in in_tdata[63:0], mode in in_tuser[1:0]
//           (0 int32, 1 int64, 2 date, 3 timestamp; 32-bit modes use the low half).
//   out_* : bin start in out_tdata[63:0], status in out_tuser[1:0]
//           (0 ok, 1 size not positive, 2 out of range, 3 non-finite date).
//   cfg_* : index 0 bin size, index 1 bin origin; always ready; write only
//           while no transaction is in flight.
// One transaction per cycle is sustained while the receiver takes results; the
// depth comes from the floor remainder, worked one dividend bit per stage over
// 64 restoring stages, plus six stages for input capture, range checks, the
// magnitude, the floor step, the bin start and the final shift by the origin.
// Reset clears all valid bits and loads bin size 1 and origin 0.
// When the receiver stalls with a result held, the whole pipeline freezes
// and in_tready drops; nothing is lost or repeated.
`default_nettype none

module grid_bin_start_top
  import gbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [63:0] in_tdata,   // [63:0] value
  input  wire logic [1:0]  in_tuser,   // [1:0] mode
  // result channel
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [63:0] out_tdata,  // [63:0] bin_start
  output      logic [1:0]  out_tuser,  // [1:0] status
  // configuration writes
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int unsigned DIV_N = DATA_W;

  logic              en;
  logic [DATA_W-1:0] bin_size_r;
  logic [DATA_W-1:0] bin_origin_r;

  logic              p0_valid_r;
  mode_t             p0_mode_r;
  logic [DATA_W-1:0] p0_value_r;

  logic              p1_valid_r;
  item_t             p1_r;
  item_t             p1_nxt;

  logic              dv_r [DIV_N+1];
  item_t             div_r [DIV_N+1];
  item_t             div0_nxt;

  logic              fx_valid_r;
  item_t             fx_r;
  item_t             fx_nxt;

  logic              bs_valid_r;
  item_t             bs_r;
  item_t             bs_nxt;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  status_t           out_status_r;
  logic [DATA_W-1:0] out_data_nxt;
  status_t           out_status_nxt;

  // global advance: move while the output register is free or being taken
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_size_r   <= 64'd1;
      bin_origin_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BIN_SIZE:   bin_size_r   <= cfg_data;
        CFG_BIN_ORIGIN: bin_origin_r <= cfg_data;
        default:        ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_valid_r <= 1'b0;
    end else if (en) begin
      p0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_mode_r  <= mode_t'(in_tuser);
      p0_value_r <= in_tdata;
    end
  end

  // narrowing, special values and origin shift
  always_comb begin
    logic                     nar;
    logic [DATA_W-1:0]        v;
    logic [DATA_W-1:0]        sz;
    logic [DATA_W-1:0]        org;
    logic [DATA_W-1:0]        lo;
    logic [DATA_W-1:0]        hi;
    logic signed [WIDE_W-1:0] d_w;
    nar = (p0_mode_r == MODE_INT32) || (p0_mode_r == MODE_DATE);
    v   = narrow_ext(p0_value_r, nar);
    sz  = narrow_ext(bin_size_r, nar);
    org = narrow_ext(bin_origin_r, nar);
    lo  = lo_of(nar);
    hi  = hi_of(nar);
    d_w = sx_wide(v) - sx_wide(org);
    p1_nxt        = '0;
    p1_nxt.narrow = nar;
    p1_nxt.status = ST_OK;
    p1_nxt.d      = d_w[DATA_W-1:0];
    if ($signed(sz) <= $signed(64'd0)) begin
      p1_nxt.done   = 1'b1;
      p1_nxt.status = ST_SIZE;
    end else if (p0_mode_r == MODE_DATE && (v == lo || v == hi)) begin
      p1_nxt.done   = 1'b1;
      p1_nxt.status = ST_NONFINITE;
      p1_nxt.d      = v;
    end else if (p0_mode_r == MODE_TS && (v == lo || v == hi)) begin
      p1_nxt.done   = 1'b1;
      p1_nxt.status = ST_RANGE;
    end else if (d_w < sx_wide(lo) || d_w > sx_wide(hi)) begin
      p1_nxt.done   = 1'b1;
      p1_nxt.status = ST_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r <= p0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= p1_nxt;
    end
  end

  // magnitude of the shifted value, divider entry
  always_comb begin
    div0_nxt     = p1_r;
    div0_nxt.mag = p1_r.d[DATA_W-1] ? (~p1_r.d + 64'd1) : p1_r.d;
    div0_nxt.rem = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0] <= div0_nxt;
    end
  end

  // restoring remainder, one dividend bit per stage from the top
  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    item_t             stg_nxt;
    logic [DATA_W-1:0] stg_size;

    always_comb begin
      stg_size     = narrow_ext(bin_size_r, div_r[k].narrow);
      stg_nxt      = div_r[k];
      stg_nxt.rem  = rem_step(div_r[k].rem, div_r[k].mag[DATA_W-1-k], stg_size);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_r[k+1] <= stg_nxt;
      end
    end
  end

  // floor remainder: a negative value with a remainder steps one bin down
  always_comb begin
    logic [DATA_W-1:0] sz;
    sz     = narrow_ext(bin_size_r, div_r[DIV_N].narrow);
    fx_nxt = div_r[DIV_N];
    if (div_r[DIV_N].d[DATA_W-1] && div_r[DIV_N].rem != '0) begin
      fx_nxt.mag = sz - {1'b0, div_r[DIV_N].rem};
    end else begin
      fx_nxt.mag = {1'b0, div_r[DIV_N].rem};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_valid_r <= 1'b0;
    end else if (en) begin
      fx_valid_r <= dv_r[DIV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx_r <= fx_nxt;
    end
  end

  // bin start before the origin, underflow check
  always_comb begin
    logic signed [WIDE_W-1:0] b_w;
    b_w    = sx_wide(fx_r.d) - $signed({2'b00, fx_r.mag});
    bs_nxt = fx_r;
    if (!fx_r.done) begin
      bs_nxt.d = b_w[DATA_W-1:0];
      if (b_w < sx_wide(lo_of(fx_r.narrow))) begin
        bs_nxt.done   = 1'b1;
        bs_nxt.status = ST_RANGE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_valid_r <= 1'b0;
    end else if (en) begin
      bs_valid_r <= fx_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bs_r <= bs_nxt;
    end
  end

  // shift back by the origin and pick the result
  always_comb begin
    logic [DATA_W-1:0]        org;
    logic [DATA_W-1:0]        hi;
    logic signed [WIDE_W-1:0] r_w;
    org = narrow_ext(bin_origin_r, bs_r.narrow);
    hi  = hi_of(bs_r.narrow);
    r_w = sx_wide(bs_r.d) + sx_wide(org);
    if (bs_r.done) begin
      out_status_nxt = bs_r.status;
      out_data_nxt   = (bs_r.status == ST_NONFINITE) ? bs_r.d : hi;
    end else if (r_w < sx_wide(lo_of(bs_r.narrow)) || r_w > sx_wide(hi)) begin
      out_status_nxt = ST_RANGE;
      out_data_nxt   = hi;
    end else begin
      out_status_nxt = ST_OK;
      out_data_nxt   = r_w[DATA_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= bs_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

// File: design/gbs_checker.sv
// gbs_checker: port-level assertions for grid_bin_start_top, bound below
// depends on gbs_pkg and grid_bin_start_top_defines.svh
`default_nettype none
`include "grid_bin_start_top_defines.svh"

module gbs_checker
  import gbs_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  logic        out_held;
  logic [65:0] out_word;
  logic        err_res;
  logic        at_max;
  logic        nf_res;
  logic        at_inf;

  // result channel terms
  assign out_held = out_tvalid && !out_tready;
  assign out_word = {out_tuser, out_tdata};
  assign err_res  = out_tvalid && (out_tuser == ST_SIZE || out_tuser == ST_RANGE);
  assign at_max   = (out_tdata == S64_MAX) || (out_tdata == INT32_MAX_X);
  assign nf_res   = out_tvalid && (out_tuser == ST_NONFINITE);
  assign at_inf   = (out_tdata == INT32_MAX_X) || (out_tdata == INT32_MIN_X);

  // a held result must not change while the receiver stalls
  `GBS_ASSERT_NEXT(a_out_hold, out_held, out_tvalid && $stable(out_word), "result changed")

  // the input side only stalls behind a held result
  `GBS_ASSERT_NOW(a_in_stall, !in_tready, out_held, "input stalled with output free")

  // error statuses return the type maximum
  `GBS_ASSERT_NOW(a_err_max, err_res, at_max, "error without type maximum")

  // a non-finite date comes back as a 32-bit limit
  `GBS_ASSERT_NOW(a_nonfinite, nf_res, at_inf, "non-finite date altered")

endmodule

bind grid_bin_start_top gbs_checker u_gbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// File: sim/grid_bin_start_top_tb.sv
// grid_bin_start_top_tb: self-checking bench for the grid bin start pipeline
// depends on gbs_pkg and grid_bin_start_top; predicts each bin start and status
// itself and compares every result transaction against it in order
`default_nettype none

module grid_bin_start_top_tb
  import gbs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT = 200_000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_WAIT  = 80;
  localparam int          MAX_PRINTED = 30;
  localparam logic [63:0] JUNK_HI     = 64'hDEAD_BEEF_0000_0000;

  // expected result of one transaction
  typedef struct packed {
    logic [63:0] bin_start;
    status_t     status;
  } bin_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [63:0] cfg_data;

  // bench-side copy of the two registers
  logic [63:0] size_reg;
  logic [63:0] origin_reg;

  bin_result_t bin_results_q[$];
  logic        idle_on;
  logic        hold_on;
  event        hold_ev;
  int          err_count;
  int          items_sent;
  int          results_checked;
  int          phases_run;
  int          cycle_count;

  grid_bin_start_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               bin_results_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // floor binning of one value under the current bin size and origin
  function automatic bin_result_t bin_of(mode_t mode, logic [63:0] value);
    logic        narrow;
    logic        ok;
    longint      lo, hi, v, sz, org, q, r, b;
    bin_result_t res;
    narrow = (mode == MODE_INT32 || mode == MODE_DATE);
    if (narrow) begin
      lo  = -64'sd2147483648;
      hi  = 64'sd2147483647;
      v   = $signed(value[31:0]);
      sz  = $signed(size_reg[31:0]);
      org = $signed(origin_reg[31:0]);
    end else begin
      lo  = S64_MIN;
      hi  = S64_MAX;
      v   = value;
      sz  = size_reg;
      org = origin_reg;
    end
    res.bin_start = hi;
    res.status    = ST_OK;
    ok            = 1'b1;
    if (sz <= 0) begin
      res.status = ST_SIZE;
    end else if (mode == MODE_DATE && (v == lo || v == hi)) begin
      // infinite dates pass through unchanged
      res.bin_start = v;
      res.status    = ST_NONFINITE;
    end else if (mode == MODE_TS && (v == lo || v == hi)) begin
      res.status = ST_RANGE;
    end else if ((org > 0 && v < lo + org) || (org < 0 && v > hi + org)) begin
      res.status = ST_RANGE;
    end else begin
      v = v - org;
      q = v / sz;
      r = v % sz;
      b = q * sz;
      // truncation rounds towards zero, step one bin down for negatives
      if (v < 0 && r != 0) begin
        if (b < lo + sz) ok = 1'b0;
        else b = b - sz;
      end
      if (ok && ((org > 0 && b > hi - org) || (org < 0 && b < lo - org))) ok = 1'b0;
      if (ok) res.bin_start = b + org;
      else res.status = ST_RANGE;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_on) out_tready <= 1'b0;
    else if (idle_on && $urandom_range(99) < 10) out_tready <= 1'b0;
    else out_tready <= 1'b1;
  end

  // hold-off length counted here
  initial begin
    forever begin
      @(hold_ev);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    bin_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (bin_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h status %0d", out_tdata, out_tuser));
      end else begin
        exp_res = bin_results_q.pop_front();
        if (out_tdata !== exp_res.bin_start)
          report_mismatch($sformatf("bin_start %h, expected %h", out_tdata,
                                    exp_res.bin_start));
        if (out_tuser !== exp_res.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_tuser, exp_res.status));
      end
    end
  end

  // one input transaction, with an occasional gap before it
  task automatic send_item(input mode_t mode, input logic [63:0] value);
    if (idle_on && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    bin_results_q.push_back(bin_of(mode, value));
    items_sent++;
  endtask

  // stop offering and wait for every expected result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (bin_results_q.size() != 0);
  endtask

  // both registers, written once the pipeline is empty
  task automatic set_config(input logic [63:0] size, input logic [63:0] origin);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_BIN_SIZE;
    cfg_data  <= size;
    do @(posedge clk); while (!cfg_ready);
    size_reg  = size;
    cfg_index <= CFG_BIN_ORIGIN;
    cfg_data  <= origin;
    do @(posedge clk); while (!cfg_ready);
    origin_reg = origin;
    cfg_valid <= 1'b0;
    phases_run++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_size();
    case ($urandom_range(9))
      0:       return 64'd1;
      1:       return 64'($urandom_range(2, 100));
      2:       return 64'd1 << $urandom_range(1, 62);
      3:       return rand64();
      4:       return S64_MAX;
      5:       return {$urandom, 32'h7FFF_FFFF};
      6:       return -64'($urandom_range(0, 3));
      7:       return {$urandom, 32'($urandom_range(1, 5000))};
      default: return 64'($urandom_range(1, 1_000_000));
    endcase
  endfunction

  function automatic logic [63:0] rand_origin();
    case ($urandom_range(7))
      0:       return 64'd0;
      1:       return 64'($urandom_range(2000)) - 64'd1000;
      2:       return S64_MIN;
      3:       return S64_MAX;
      4:       return {$urandom, 32'h8000_0000 | 32'($urandom_range(7))};
      5:       return {$urandom, 32'h7FFF_FFFF - 32'($urandom_range(7))};
      default: return rand64();
    endcase
  endfunction

  // values spread over the whole range, bin boundaries and type limits
  function automatic logic [63:0] rand_value();
    longint k;
    k = longint'($urandom_range(20)) - 10;
    case ($urandom_range(6))
      0:       return 64'($urandom_range(2000)) - 64'd1000;
      1:       return origin_reg + size_reg * k + 64'($urandom_range(4)) - 64'd2;
      2:       return S64_MIN + 64'($urandom_range(3));
      3:       return S64_MAX - 64'($urandom_range(3));
      4:       return {$urandom, 32'h8000_0000 + 32'($urandom_range(3))};
      5:       return {$urandom, 32'h7FFF_FFFF - 32'($urandom_range(3))};
      default: return rand64();
    endcase
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_item(mode_t'($urandom_range(3)), rand_value());
  endtask

  // registers straight out of reset: size 1, origin 0
  task automatic test_reset_defaults();
    send_item(MODE_INT32, JUNK_HI | 64'h0000_0000_FFFF_FFF6);
    send_item(MODE_TS, 64'd123_456_789);
  endtask

  // ordinary floor binning in all four modes
  task automatic test_floor_modes();
    set_config(64'd10, 64'd3);
    send_item(MODE_INT32, JUNK_HI | 64'h0000_0000_FFFF_FFFF);
    send_item(MODE_INT64, 64'd27);
    send_item(MODE_INT64, -64'd17);
    send_item(MODE_DATE, 64'd0);
    send_item(MODE_TS, -64'd1);
  endtask

  // infinite dates and timestamps, type limits meeting the origin
  task automatic test_nonfinite();
    send_item(MODE_DATE, JUNK_HI | 64'h0000_0000_8000_0000);
    send_item(MODE_DATE, 64'h0000_0000_7FFF_FFFF);
    send_item(MODE_TS, S64_MIN);
    send_item(MODE_TS, S64_MAX);
    send_item(MODE_INT32, INT32_MAX_X);
    send_item(MODE_INT32, INT32_MIN_X);
    send_item(MODE_INT64, S64_MIN);
  endtask

  // origin overflow, floor underflow and overflow of the final shift
  task automatic test_range_faults();
    set_config(64'd8, -64'd5);
    send_item(MODE_INT64, S64_MIN + 64'd1);
    send_item(MODE_INT32, JUNK_HI | 64'h0000_0000_8000_0001);
    send_item(MODE_INT64, S64_MAX - 64'd2);
    send_item(MODE_TS, S64_MAX - 64'd1);
    set_config(64'd1000, 64'd0);
    send_item(MODE_INT64, S64_MIN + 64'd1);
    send_item(MODE_INT32, 64'h0000_0000_8000_0001);
  endtask

  // bin size zero or negative on the width each mode uses
  task automatic test_bad_size();
    set_config(64'd0, 64'd0);
    send_item(MODE_INT64, 64'd5);
    set_config(64'h0000_0001_8000_0000, 64'd0);
    send_item(MODE_INT32, 64'd5);
    send_item(MODE_INT64, 64'd5);
    set_config(64'hFFFF_FFFF_0000_0010, 64'd0);
    send_item(MODE_TS, 64'd5);
    send_item(MODE_DATE, 64'd33);
  endtask

  // random phases, the first two at register extremes
  task automatic test_random_phases();
    set_config(S64_MAX, S64_MIN);
    send_random(50);
    set_config(64'd1, S64_MAX);
    send_random(50);
    set_config(S64_MIN, rand64());
    send_random(30);
    repeat (6) begin
      set_config(rand_size(), rand_origin());
      send_random(30);
    end
  endtask

  // both sides always ready for a stretch
  task automatic test_no_idle();
    set_config(64'($urandom_range(1, 64)), rand_origin());
    idle_on <= 1'b0;
    send_random(60);
    drain_results();
    idle_on <= 1'b1;
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    set_config(64'($urandom_range(1, 500)), rand_origin());
    -> hold_ev;
    send_random(120);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tuser        = '0;
    out_tready      = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = 1'b0;
    cfg_data        = '0;
    idle_on         = 1'b1;
    hold_on         = 1'b0;
    size_reg        = 64'd1;
    origin_reg      = 64'd0;
    err_count       = 0;
    items_sent      = 0;
    results_checked = 0;
    phases_run      = 0;
    cycle_count     = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_floor_modes();
    test_nonfinite();
    test_range_faults();
    test_bad_size();
    test_random_phases();
    test_no_idle();
    test_backpressure();

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d transactions in all four modes over %0d register settings", items_sent,
             phases_run);
    $display("%0d results checked, %0d mismatches", results_checked, err_count);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
